/* hw/rtl/fmtk_pkg.sv */
// Shared types, codes and a helper function for the fuzzy match top-k block.
package fmtk_pkg;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned SCORE_W = 12;
   localparam int unsigned CSR_W   = 64;
   localparam int unsigned LEN_W   = 5;
   localparam int unsigned PAT_W   = 128;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 12'sd2047;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = -12'sd2048;

   localparam logic signed [SCORE_W:0] ADD_MATCH = 13'sd5;
   localparam logic signed [SCORE_W:0] ADD_BONUS = 13'sd7;
   localparam logic signed [SCORE_W:0] ADD_MISS  = -13'sd1;

   typedef enum logic [1:0] {
      MODE_CHAR  = 2'd0,
      MODE_EOL   = 2'd1,
      MODE_FLUSH = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [CH_W-1:0] ch;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [IDX_W-1:0]          line_index;
      logic signed [SCORE_W-1:0] line_score;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic take_char;
      logic end_line;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_entry;
   } status_type;

   function automatic logic [CH_W-1:0] fold(input logic [CH_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         fold = c + 8'h20;
      end else begin
         fold = c;
      end
   endfunction

endpackage

/* hw/rtl/fmtk_ctrl.sv */
// Controller state machine: accepts beats and sequences the flush read-out.
module fmtk_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   output logic                req_stall,
   input  fmtk_pkg::status_type status,
   output fmtk_pkg::cmd_type    cmd
);
   import fmtk_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.take_char = accept && (req_mode == MODE_CHAR);
      cmd.end_line  = accept && (req_mode == MODE_EOL);
      cmd.emit      = (state_ff == ST_FLUSH) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_FLUSH)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.out_free && status.last_entry) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/fmtk_dp.sv */
// Datapath: pattern registers, line scoring, sorted top list and output register.
module fmtk_dp #(
   parameter int unsigned MAX_LINES      = 4096,
   parameter int unsigned MAX_LINE_CHARS = 255,
   parameter int unsigned TOP_COUNT      = 10,
   parameter int unsigned PATTERN_CHARS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [fmtk_pkg::CSR_W-1:0]  csr_data,
   input  logic [fmtk_pkg::CH_W-1:0]   req_ch,
   input  fmtk_pkg::cmd_type           cmd,
   output fmtk_pkg::status_type        status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fmtk_pkg::rsp_type           rsp_data
);
   import fmtk_pkg::*;

   localparam int unsigned LC_W = $clog2(MAX_LINES + 1);
   localparam int unsigned CS_W = $clog2(MAX_LINE_CHARS + 1);
   localparam int unsigned PP_W = $clog2(PATTERN_CHARS + 1);

   logic [PAT_W-1:0] pattern_ff;
   logic [LEN_W-1:0] pattern_len_ff;

   logic [PP_W-1:0]           pattern_pos_ff;
   logic [CH_W-1:0]           prev_char_ff;
   logic [CS_W-1:0]           chars_seen_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic [LC_W-1:0]           line_counter_ff;

   logic [TOP_COUNT-1:0]      valid_ff;
   logic [TOP_COUNT-1:0]      valid_in;
   logic [IDX_W-1:0]          index_ff [TOP_COUNT];
   logic [IDX_W-1:0]          index_in [TOP_COUNT];
   logic signed [SCORE_W-1:0] list_score_ff [TOP_COUNT];
   logic signed [SCORE_W-1:0] list_score_in [TOP_COUNT];
   logic [TOP_COUNT-1:0]      better;
   logic [TOP_COUNT-1:0]      valid_up;

   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   logic [PP_W-1:0]           len_eff;
   logic [3:0]                pos_idx;
   logic [3:0]                prev_idx;
   logic [CH_W-1:0]           pat_cur;
   logic [CH_W-1:0]           pat_prev;
   logic                      char_hit;
   logic                      bonus;
   logic signed [SCORE_W:0]   add;
   logic signed [SCORE_W:0]   sum;
   logic signed [SCORE_W-1:0] sum_sat;
   logic                      do_insert;
   logic [IDX_W-1:0]          new_index;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         pattern_len_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pattern_ff[CSR_W-1:0]     <= csr_data;
            CSR_PATTERN_HIGH: pattern_ff[PAT_W-1:CSR_W] <= csr_data;
            CSR_PATTERN_LEN:  pattern_len_ff            <= csr_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // scoring
   assign len_eff  = (pattern_len_ff > LEN_W'(PATTERN_CHARS)) ? PP_W'(PATTERN_CHARS)
                                                              : PP_W'(pattern_len_ff);
   assign pos_idx  = 4'(pattern_pos_ff);
   assign prev_idx = 4'(pattern_pos_ff - PP_W'(1));
   assign pat_cur  = pattern_ff[{pos_idx, 3'b000} +: CH_W];
   assign pat_prev = pattern_ff[{prev_idx, 3'b000} +: CH_W];
   assign char_hit = fold(req_ch) == fold(pat_cur);
   assign bonus    = (chars_seen_ff != '0) && (pattern_pos_ff != '0) &&
                     (fold(prev_char_ff) == fold(pat_prev));
   assign add      = char_hit ? (bonus ? ADD_BONUS : ADD_MATCH) : ADD_MISS;
   assign sum      = {score_ff[SCORE_W-1], score_ff} + add;

   always_comb begin
      if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         sum_sat = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sum_sat = sum[SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_pos_ff  <= '0;
         prev_char_ff    <= '0;
         chars_seen_ff   <= '0;
         score_ff        <= '0;
         line_counter_ff <= '0;
      end else if (cmd.end_line) begin
         pattern_pos_ff <= '0;
         prev_char_ff   <= '0;
         chars_seen_ff  <= '0;
         score_ff       <= '0;
         if (line_counter_ff < LC_W'(MAX_LINES)) begin
            line_counter_ff <= line_counter_ff + LC_W'(1);
         end
      end else if (cmd.take_char && (chars_seen_ff < CS_W'(MAX_LINE_CHARS))) begin
         if (pattern_pos_ff < len_eff) begin
            score_ff <= sum_sat;
            if (char_hit) begin
               pattern_pos_ff <= pattern_pos_ff + PP_W'(1);
            end
         end
         prev_char_ff  <= req_ch;
         chars_seen_ff <= chars_seen_ff + CS_W'(1);
      end
   end

   // sorted list: insert by shift chain, read out by shifting towards the head
   assign do_insert = cmd.end_line && (line_counter_ff < LC_W'(MAX_LINES)) &&
                      (pattern_pos_ff >= len_eff);
   assign new_index = IDX_W'(line_counter_ff);
   assign valid_up  = valid_ff >> 1;

   always_comb begin
      for (int k = 0; k < TOP_COUNT; k++) begin
         better[k] = !valid_ff[k] || (list_score_ff[k] < score_ff);
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      index_in      = index_ff;
      list_score_in = list_score_ff;
      priority if (cmd.emit) begin
         valid_in = valid_up;
         for (int k = 0; k < TOP_COUNT - 1; k++) begin
            index_in[k]      = index_ff[k+1];
            list_score_in[k] = list_score_ff[k+1];
         end
      end else if (do_insert) begin
         if (better[0]) begin
            valid_in[0]      = 1'b1;
            index_in[0]      = new_index;
            list_score_in[0] = score_ff;
         end
         for (int k = 1; k < TOP_COUNT; k++) begin
            if (better[k-1]) begin
               valid_in[k]      = valid_ff[k-1];
               index_in[k]      = index_ff[k-1];
               list_score_in[k] = list_score_ff[k-1];
            end else if (better[k]) begin
               valid_in[k]      = 1'b1;
               index_in[k]      = new_index;
               list_score_in[k] = score_ff;
            end
         end
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff      <= index_in;
      list_score_ff <= list_score_in;
   end

   // output register
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.last_entry = !valid_ff[0] || !valid_up[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.found      <= valid_ff[0];
         rsp_ff.line_index <= valid_ff[0] ? index_ff[0] : '0;
         rsp_ff.line_score <= valid_ff[0] ? list_score_ff[0] : '0;
         rsp_ff.last       <= status.last_entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/fuzzy_match_top_k_top.sv */
// Top level of the fuzzy subsequence matcher with a sorted top-k line list.
// Throughput: one character or end-of-line beat per cycle while no flush stalls req_;
// scoring and the list insert each finish in the cycle the beat is taken.
// A flush, once accepted, emits one result per cycle from the output register while
// rsp_stall allows (one per kept line, at least one result) and stalls req_ until done.
// Reset (synchronous, active high) clears pattern registers, line state and list.
module fuzzy_match_top_k_top #(
   parameter int unsigned MAX_LINES      = 4096,
   parameter int unsigned MAX_LINE_CHARS = 255,
   parameter int unsigned TOP_COUNT      = 10,
   parameter int unsigned PATTERN_CHARS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fmtk_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fmtk_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [fmtk_pkg::CSR_W-1:0] csr_data
);
   import fmtk_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fmtk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fmtk_dp #(
      .MAX_LINES      (MAX_LINES),
      .MAX_LINE_CHARS (MAX_LINE_CHARS),
      .TOP_COUNT      (TOP_COUNT),
      .PATTERN_CHARS  (PATTERN_CHARS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_ch    (req_data.ch),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last)
      else $error("empty flush beat without last");

   a_flush_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == MODE_FLUSH) |=> req_stall)
      else $error("flush accepted but input not held off");

   a_emit_in_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> req_stall && !cmd.end_line && !cmd.take_char)
      else $error("result emitted outside flush");

endmodule
